// File: rtl/scfr_pkg.sv
// Package for the sync-word frame receiver: command and status types between
// controller and datapath, register indexes and the CRC-8 step function.
// No dependencies.
package scfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THIRD  = 2'd2;

    localparam logic       OP_BYTE  = 1'b0;
    localparam logic       OP_REARM = 1'b1;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    typedef struct packed {
        logic clear;
        logic store;
        logic load_err;
        logic rd_en;
    } scfr_cmd_t;

    typedef struct packed {
        logic first_hit;
        logic second_hit;
        logic third_hit;
        logic crc_hit;
        logic count_last;
        logic out_free;
    } scfr_sts_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

// File: rtl/scfr_ctrl.sv
// Controller of the frame receiver: hunt, payload, CRC, emit and hold phases.
// Depends on scfr_pkg; drives datapath commands from datapath status.
module scfr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  scfr_pkg::scfr_sts_t sts,
    output scfr_pkg::scfr_cmd_t cmd
);
    import scfr_pkg::*;

    localparam logic [2:0] ST_HUNT0 = 3'd0;
    localparam logic [2:0] ST_HUNT1 = 3'd1;
    localparam logic [2:0] ST_HUNT2 = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg != ST_EMIT) && ((state_reg != ST_CRC) || sts.out_free);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        if (state_reg == ST_EMIT) begin
            if (sts.out_free) begin
                cmd.rd_en = 1'b1;
                if (sts.count_last) begin
                    state_next = ST_HOLD;
                end
            end
        end else if (accept) begin
            if (s_tuser == OP_REARM) begin
                cmd.clear  = 1'b1;
                state_next = ST_HUNT0;
            end else begin
                unique case (state_reg)
                    ST_HUNT1: state_next = sts.second_hit ? ST_HUNT2 : ST_HUNT0;
                    ST_HUNT2: state_next = sts.third_hit ? ST_DATA : ST_HUNT0;
                    ST_DATA: begin
                        cmd.store = 1'b1;
                        if (sts.count_last) begin
                            state_next = ST_CRC;
                        end
                    end
                    ST_CRC: begin
                        cmd.clear = 1'b1;
                        if (sts.crc_hit) begin
                            state_next = ST_EMIT;
                        end else begin
                            cmd.load_err = 1'b1;
                            state_next   = ST_HUNT0;
                        end
                    end
                    ST_HOLD: state_next = ST_HOLD;
                    default: begin
                        cmd.clear  = 1'b1;
                        state_next = sts.first_hit ? ST_HUNT1 : ST_HUNT0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT0;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !s_tready)
        else $error("input accepted during emission");

    a_err_needs_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_err |-> sts.out_free)
        else $error("error item loaded over a pending item");

    a_emit_ends_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && sts.out_free && sts.count_last) |=> (state_reg == ST_HOLD))
        else $error("emission did not end in hold");

endmodule

// File: rtl/scfr_dp.sv
// Datapath of the frame receiver: sync registers, CRC-8, payload memory,
// byte counter and output register. Depends on scfr_pkg; commanded by scfr_ctrl.
module scfr_dp #(
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [scfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scfr_pkg::BYTE_W-1:0]          cfg_wdata,
    input  logic [scfr_pkg::BYTE_W-1:0]          s_tdata,
    input  scfr_pkg::scfr_cmd_t                  cmd,
    output scfr_pkg::scfr_sts_t                  sts,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scfr_pkg::BYTE_W-1:0]          m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import scfr_pkg::*;

    localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] sync_third_reg;
    logic [BYTE_W-1:0] crc_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] mem [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    assign sts.first_hit  = (s_tdata == sync_first_reg);
    assign sts.second_hit = (s_tdata == sync_second_reg);
    assign sts.third_hit  = (s_tdata == sync_third_reg);
    assign sts.crc_hit    = (s_tdata == crc_reg);
    assign sts.count_last = (count_reg == CNT_LAST);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_err_reg ? '0 : rd_data_reg;
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
            sync_third_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                REG_SYNC_THIRD:  sync_third_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.clear) begin
            crc_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.store) begin
            crc_reg   <= crc8_step(crc_reg, s_tdata);
            count_reg <= count_reg + 1'b1;
        end else if (cmd.rd_en) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[count_reg] <= s_tdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[count_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_err_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (cmd.load_err) begin
            out_valid_reg <= 1'b1;
            out_err_reg   <= 1'b1;
            out_last_reg  <= 1'b1;
        end else if (cmd.rd_en) begin
            out_valid_reg <= 1'b1;
            out_err_reg   <= 1'b0;
            out_last_reg  <= sts.count_last;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_err_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_err |=> (m_tvalid && m_tuser && m_tlast && (m_tdata == '0)))
        else $error("error item not presented");

    a_read_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> (m_tvalid && !m_tuser))
        else $error("payload item not presented");

    a_no_cmd_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_err && cmd.rd_en) && !(cmd.store && cmd.rd_en))
        else $error("conflicting datapath commands");

endmodule

// File: rtl/sync_crc8_frame_receiver.sv
// Sync-word frame receiver with CRC-8 (poly 0x31, init 0, MSB first) check.
// Takes one input item per cycle while hunting, storing or holding.
// CRC mismatch: error item on the output in the cycle after the CRC byte is taken.
// CRC match: after the emit state is registered, payload items come one per cycle,
// output stalls apart, from the registered memory read; input stalls during emission.
// Reset: hunt for first sync byte; CRC, count and sync registers zero, memory kept.
module sync_crc8_frame_receiver #(
    parameter int PAYLOAD_BYTES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [scfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scfr_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scfr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scfr_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] payload_byte
    output logic                           m_tuser,   // [0] frame_status
    output logic                           m_tlast
);
    import scfr_pkg::*;

    scfr_cmd_t cmd;
    scfr_sts_t sts;

    scfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scfr_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for sync_crc8_frame_receiver: sends byte and rearm items, predicts every
// payload and error item with a local deframer model and checks them in order.
// Depends on scfr_pkg and the receiver RTL.
module testbench;
    import scfr_pkg::*;

    localparam int PAYLOAD_BYTES = 16;
    localparam int SETTLE_CYCLES = PAYLOAD_BYTES + 8;
    localparam int PHASE_ITEMS   = 86;
    localparam logic [BYTE_W-1:0] POLY_CRC8 = 8'h31;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, HUNT_THIRD, TAKE_PAYLOAD, TAKE_CRC, HOLD_FRAME
    } rx_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              dropped;
        logic              last;
    } frame_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = OP_BYTE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    logic [BYTE_W-1:0] sync_value [3];
    rx_phase_e         rx_phase;
    logic [BYTE_W-1:0] frame_crc;
    int unsigned       bytes_stored;
    logic [BYTE_W-1:0] payload_copy [PAYLOAD_BYTES];
    frame_item_t       pending_items [$];
    frame_item_t       oldest;
    int                mismatches     = 0;
    int                items_sent     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;

    sync_crc8_frame_receiver #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("FAIL sync_crc8_frame_receiver");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = crc ^ b;
        repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ POLY_CRC8) : (r << 1);
        return r;
    endfunction

    function automatic void clear_deframer();
        rx_phase     = HUNT_FIRST;
        frame_crc    = '0;
        bytes_stored = 0;
        foreach (payload_copy[i]) payload_copy[i] = '0;
    endfunction

    function automatic void advance_deframer(input logic op, input logic [BYTE_W-1:0] b);
        frame_item_t item;
        if (op == OP_REARM) begin
            clear_deframer();
            return;
        end
        case (rx_phase)
            HUNT_SECOND: rx_phase = (b == sync_value[REG_SYNC_SECOND]) ? HUNT_THIRD : HUNT_FIRST;
            HUNT_THIRD: rx_phase = (b == sync_value[REG_SYNC_THIRD]) ? TAKE_PAYLOAD : HUNT_FIRST;
            TAKE_PAYLOAD: begin
                frame_crc = crc8_next(frame_crc, b);
                payload_copy[bytes_stored] = b;
                bytes_stored++;
                if (bytes_stored >= PAYLOAD_BYTES) rx_phase = TAKE_CRC;
            end
            TAKE_CRC: begin
                if (b == frame_crc) begin
                    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                        item.data    = payload_copy[i];
                        item.dropped = 1'b0;
                        item.last    = (i == PAYLOAD_BYTES - 1);
                        pending_items.push_back(item);
                    end
                    rx_phase = HOLD_FRAME;
                end else begin
                    item.data    = '0;
                    item.dropped = 1'b1;
                    item.last    = 1'b1;
                    pending_items.push_back(item);
                    clear_deframer();
                end
            end
            HOLD_FRAME: ;
            default: begin
                frame_crc    = '0;
                bytes_stored = 0;
                rx_phase = (b == sync_value[REG_SYNC_FIRST]) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_items.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, 0);
            end else begin
                oldest = pending_items.pop_front();
                if (m_tdata !== oldest.data) report_mismatch("payload_byte", m_tdata, oldest.data);
                if (m_tuser !== oldest.dropped)
                    report_mismatch("frame_status", m_tuser, oldest.dropped);
                if (m_tlast !== oldest.last) report_mismatch("frame_last", m_tlast, oldest.last);
            end
        end
    end

    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        advance_deframer(op, b);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                                input logic [BYTE_W-1:0] third);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [BYTE_W-1:0]    vals [3];
        regs = '{REG_SYNC_FIRST, REG_SYNC_SECOND, REG_SYNC_THIRD};
        vals = '{first, second, third};
        wait_idle();
        for (int r = 0; r < 3; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[r];
            cfg_wdata <= vals[r];
            @(posedge aclk);
            sync_value[regs[r]] = vals[r];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input bit bad_crc, input bit extremes);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        crc = '0;
        send_item(OP_BYTE, sync_value[REG_SYNC_FIRST]);
        send_item(OP_BYTE, sync_value[REG_SYNC_SECOND]);
        send_item(OP_BYTE, sync_value[REG_SYNC_THIRD]);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            b = 8'($urandom);
            if (extremes && i == 0) b = 8'h00;
            if (extremes && i == PAYLOAD_BYTES - 1) b = 8'hFF;
            crc = crc8_next(crc, b);
            send_item(OP_BYTE, b);
        end
        send_item(OP_BYTE, bad_crc ? crc ^ 8'($urandom_range(255, 1)) : crc);
    endtask

    task automatic test_default_sync_frame();
        send_frame(1'b0, 1'b1);
        send_item(OP_BYTE, 8'($urandom));
        send_item(OP_REARM, 8'($urandom));
    endtask

    task automatic test_rearm_in_hunt();
        send_item(OP_BYTE, sync_value[REG_SYNC_FIRST]);
        send_item(OP_REARM, 8'hFF);
        send_item(OP_BYTE, 8'h55);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [BYTE_W-1:0] first,
                                       input logic [BYTE_W-1:0] second,
                                       input logic [BYTE_W-1:0] third);
        int  stop_at;
        int  pick;
        int  k;
        bit  paused;
        program_sync(first, second, third);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + PHASE_ITEMS;
        paused  = 1'b0;
        while (items_sent < stop_at) begin
            if (!paused && items_sent >= stop_at - PHASE_ITEMS / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_frame($urandom_range(99) < 25, 1'b0);
                if ($urandom_range(99) < 85) send_item(OP_REARM, 8'($urandom));
            end else if (pick < 70) begin
                k = $urandom_range(2, 1);
                for (int j = 0; j < k; j++) send_item(OP_BYTE, sync_value[j]);
                send_item(OP_BYTE, 8'($urandom));
            end else if (pick < 82) begin
                for (int j = 0; j < 3; j++) send_item(OP_BYTE, sync_value[j]);
                repeat ($urandom_range(PAYLOAD_BYTES)) send_item(OP_BYTE, 8'($urandom));
                send_item(OP_REARM, 8'($urandom));
            end else begin
                repeat ($urandom_range(4, 1))
                    send_item(($urandom_range(99) < 15) ? OP_REARM : OP_BYTE, 8'($urandom));
            end
        end
    endtask

    initial begin
        foreach (sync_value[i]) sync_value[i] = '0;
        clear_deframer();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_sync_frame();
        test_rearm_in_hunt();
        test_random_traffic(0, 0, 8'hFF, 8'hFF, 8'hFF);
        test_random_traffic(81, 0, 8'h00, 8'hFF, 8'h00);
        test_random_traffic(0, 81, 8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(6, 6, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
        if (mismatches == 0) begin
            $display("PASS sync_crc8_frame_receiver");
        end else begin
            $display("FAIL sync_crc8_frame_receiver");
        end
        $finish;
    end

endmodule
